// ===== sv/bpq_pkg.sv =====
// shared constants, codes and types of the bucket priority queue
package bpq_pkg;

  localparam int MAX_POINTS_DEF  = 4096;
  localparam int NUM_BUCKETS_DEF = 16;

  localparam int          NUM_POINTS_W   = 13;
  localparam logic [12:0] NUM_POINTS_RST = 13'd4096;

  typedef enum logic [2:0] {
    OP_ADD       = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_MOVE      = 3'd2,
    OP_INCREMENT = 3'd3,
    OP_DECREMENT = 3'd4,
    OP_QUERY     = 3'd5,
    OP_RESTART   = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_ABSENT   = 2'd2,
    ST_CONFLICT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_READ,
    S_UNLINK,
    S_LINK_A,
    S_LINK_B,
    S_FINISH
  } state_e;

endpackage

// ===== sv/bpq_ram.sv =====
// single port write, single port read memory with registered read data
module bpq_ram #(
  parameter int WIDTH  = 12,
  parameter int DEPTH  = bpq_pkg::MAX_POINTS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bucket_priority_queue.sv =====
// Bucket priority queue over numbered points, each bucket a doubly linked list in insertion
// order. The per-point priority, usable flag and both links live in four synchronous
// memories with registered read data. Any other operation than restart on a point out of
// range goes straight to its result; one in range first reads the point's entry and then, if
// it changes anything, unlinks the point and/or appends it in two link steps, writing back
// through the single write port of each memory. Restart rewrites every point entry in a
// sweep. After reset a clearing pass over all MAX_POINTS entries runs with in_stall_o high;
// configuration writes are taken throughout. The result is held in an output register, so
// a new transaction can be accepted while it waits.
module bucket_priority_queue #(
  parameter int MAX_POINTS  = bpq_pkg::MAX_POINTS_DEF,
  parameter int NUM_BUCKETS = bpq_pkg::NUM_BUCKETS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [11:0] point_i,
  input  logic signed [4:0] priority_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [11:0] next_point_o,
  output logic        next_valid_o,
  output logic        queue_done_o,
  output logic [12:0] total_count_o,
  output logic signed [4:0] point_priority_o
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int BW    = $clog2(NUM_BUCKETS);
  localparam int PW    = BW + 1;

  bpq_pkg::state_e state_q, state_d;

  logic [12:0]      num_q;
  logic [2:0]       op_q, op_d;
  logic [11:0]      p_q, p_d;
  logic signed [4:0] req_q, req_d;
  logic             in_range_q, in_range_d;
  logic             restart_q, restart_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PW-1:0]    cur_q, cur_d;
  logic             usable_q, usable_d;
  logic             new_usable_q, new_usable_d;
  logic [IDX_W-1:0] nxt_q, nxt_d;
  logic [IDX_W-1:0] prv_q, prv_d;
  logic [BW-1:0]    tgt_q, tgt_d;
  logic             do_link_q, do_link_d;
  logic [PW-1:0]    fin_prio_q, fin_prio_d;
  logic [1:0]       status_q, status_d;

  logic [IDX_W-1:0]       heads_q [NUM_BUCKETS];
  logic [IDX_W-1:0]       tails_q [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] nonempty_q, nonempty_d;
  logic [CNT_W-1:0]       held_q, held_d;
  logic [CNT_W-1:0]       ubot_q, ubot_d;

  logic              head_we, tail_we;
  logic [BW-1:0]     head_widx, tail_widx;
  logic [IDX_W-1:0]  head_wdata, tail_wdata;

  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [11:0]       out_next_q;
  logic              out_nvalid_q;
  logic              out_done_q;
  logic [12:0]       out_total_q;
  logic [4:0]        out_prio_q;
  logic              out_load;

  // memory ports
  logic             prio_we, use_we, next_we, prev_we;
  logic [IDX_W-1:0] prio_wa, use_wa, next_wa, prev_wa;
  logic [PW-1:0]    prio_wd;
  logic             use_wd;
  logic [IDX_W-1:0] next_wd, prev_wd;
  logic [IDX_W-1:0] raddr;
  logic [PW-1:0]    prio_rd;
  logic             use_rd;
  logic [IDX_W-1:0] next_rd, prev_rd;

  logic [CNT_W-1:0] eff_n;
  logic [IDX_W-1:0] p_idx, cnt_idx;
  logic [BW-1:0]    hb_idx, top;
  logic             any;
  logic [IDX_W-1:0] hb_head, hb_tail;
  logic [31:0]      head_wide, held_wide;
  logic [31:0]      prio_wide;
  int               req_i;

  bpq_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS), .ADDR_W(IDX_W)) u_prio_ram (
    .clk_i, .we_i(prio_we), .waddr_i(prio_wa), .wdata_i(prio_wd),
    .raddr_i(raddr), .rdata_o(prio_rd)
  );
  bpq_ram #(.WIDTH(1), .DEPTH(MAX_POINTS), .ADDR_W(IDX_W)) u_use_ram (
    .clk_i, .we_i(use_we), .waddr_i(use_wa), .wdata_i(use_wd),
    .raddr_i(raddr), .rdata_o(use_rd)
  );
  bpq_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS), .ADDR_W(IDX_W)) u_next_ram (
    .clk_i, .we_i(next_we), .waddr_i(next_wa), .wdata_i(next_wd),
    .raddr_i(raddr), .rdata_o(next_rd)
  );
  bpq_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS), .ADDR_W(IDX_W)) u_prev_ram (
    .clk_i, .we_i(prev_we), .waddr_i(prev_wa), .wdata_i(prev_wd),
    .raddr_i(raddr), .rdata_o(prev_rd)
  );

  always_comb begin
    if (num_q == '0) begin
      eff_n = CNT_W'(1);
    end else if (int'(num_q) > MAX_POINTS) begin
      eff_n = CNT_W'(MAX_POINTS);
    end else begin
      eff_n = CNT_W'(int'(num_q));
    end
  end

  assign raddr   = IDX_W'(point_i);
  assign p_idx   = IDX_W'(p_q);
  assign cnt_idx = cnt_q[IDX_W-1:0];
  assign req_i   = int'(req_q);

  always_comb begin
    top = '0;
    any = |nonempty_q;
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      if (nonempty_q[b]) begin
        top = BW'(b);
      end
    end
  end

  always_comb begin
    case (state_q)
      bpq_pkg::S_UNLINK: hb_idx = cur_q[BW-1:0];
      bpq_pkg::S_LINK_A: hb_idx = tgt_q;
      bpq_pkg::S_LINK_B: hb_idx = tgt_q;
      default:           hb_idx = top;
    endcase
  end

  assign hb_head = heads_q[hb_idx];
  assign hb_tail = tails_q[hb_idx];

  assign in_stall_o = (state_q != bpq_pkg::S_IDLE);
  assign out_load   = (state_q == bpq_pkg::S_FINISH) && !(out_valid_q && out_stall_i);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    p_d          = p_q;
    req_d        = req_q;
    in_range_d   = in_range_q;
    restart_d    = restart_q;
    cnt_d        = cnt_q;
    cur_d        = cur_q;
    usable_d     = usable_q;
    new_usable_d = new_usable_q;
    nxt_d        = nxt_q;
    prv_d        = prv_q;
    tgt_d        = tgt_q;
    do_link_d    = do_link_q;
    fin_prio_d   = fin_prio_q;
    status_d     = status_q;
    nonempty_d   = nonempty_q;
    held_d       = held_q;
    ubot_d       = ubot_q;
    head_we = 1'b0; head_widx = hb_idx; head_wdata = p_idx;
    tail_we = 1'b0; tail_widx = hb_idx; tail_wdata = p_idx;
    prio_we = 1'b0; prio_wa = p_idx; prio_wd = '1;
    use_we  = 1'b0; use_wa  = p_idx; use_wd  = 1'b1;
    next_we = 1'b0; next_wa = p_idx; next_wd = p_idx;
    prev_we = 1'b0; prev_wa = p_idx; prev_wd = p_idx;

    case (state_q)
      bpq_pkg::S_SWEEP: begin
        prio_we = 1'b1; prio_wa = cnt_idx;
        use_we  = 1'b1; use_wa  = cnt_idx;
        if (restart_q && (cnt_q < eff_n)) begin
          prio_wd = '0;
          next_we = 1'b1; next_wa = cnt_idx;
          next_wd = (cnt_q == eff_n - CNT_W'(1)) ? cnt_idx : cnt_idx + IDX_W'(1);
          prev_we = 1'b1; prev_wa = cnt_idx;
          prev_wd = (cnt_q == '0) ? cnt_idx : cnt_idx - IDX_W'(1);
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (int'(cnt_q) == MAX_POINTS - 1) begin
          if (restart_q) begin
            head_we = 1'b1; head_widx = '0; head_wdata = '0;
            tail_we = 1'b1; tail_widx = '0;
            tail_wdata = IDX_W'(eff_n - CNT_W'(1));
            nonempty_d = NUM_BUCKETS'(1);
            held_d     = eff_n;
            ubot_d     = eff_n;
            fin_prio_d = in_range_q ? '0 : '1;
            status_d   = bpq_pkg::ST_OK;
            state_d    = bpq_pkg::S_FINISH;
          end else begin
            state_d = bpq_pkg::S_IDLE;
          end
        end
      end
      bpq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d       = op_i;
          p_d        = point_i;
          req_d      = priority_req_i;
          in_range_d = int'(point_i) < int'(eff_n);
          fin_prio_d = '1;
          status_d   = bpq_pkg::ST_OK;
          if (bpq_pkg::op_e'(op_i) == bpq_pkg::OP_RESTART) begin
            restart_d  = 1'b1;
            cnt_d      = '0;
            nonempty_d = '0;
            state_d    = bpq_pkg::S_SWEEP;
          end else if (int'(point_i) < int'(eff_n)) begin
            state_d = bpq_pkg::S_READ;
          end else begin
            status_d = bpq_pkg::ST_RANGE;
            state_d  = bpq_pkg::S_FINISH;
          end
        end
      end
      bpq_pkg::S_READ: begin
        cur_d        = prio_rd;
        usable_d     = use_rd;
        new_usable_d = use_rd;
        nxt_d        = next_rd;
        prv_d        = prev_rd;
        fin_prio_d   = prio_rd;
        do_link_d    = 1'b0;
        state_d      = bpq_pkg::S_FINISH;
        case (bpq_pkg::op_e'(op_q))
          bpq_pkg::OP_ADD: begin
            if (!prio_rd[PW-1] || req_i < 0 || req_i >= NUM_BUCKETS) begin
              status_d = bpq_pkg::ST_CONFLICT;
            end else begin
              tgt_d     = BW'(req_i);
              do_link_d = 1'b1;
              state_d   = bpq_pkg::S_LINK_A;
            end
          end
          bpq_pkg::OP_REMOVE: begin
            if (prio_rd[PW-1]) begin
              status_d = bpq_pkg::ST_ABSENT;
            end else begin
              state_d = bpq_pkg::S_UNLINK;
            end
          end
          bpq_pkg::OP_MOVE: begin
            if (prio_rd[PW-1]) begin
              status_d = bpq_pkg::ST_ABSENT;
            end else if (req_i >= NUM_BUCKETS) begin
              status_d = bpq_pkg::ST_CONFLICT;
            end else begin
              tgt_d        = (req_i < 0) ? '0 : BW'(req_i);
              new_usable_d = !(req_i < 0);
              do_link_d    = 1'b1;
              state_d      = bpq_pkg::S_UNLINK;
            end
          end
          bpq_pkg::OP_INCREMENT: begin
            if (prio_rd[PW-1]) begin
              status_d = bpq_pkg::ST_ABSENT;
            end else if (int'($signed(prio_rd)) + 1 >= NUM_BUCKETS) begin
              status_d = bpq_pkg::ST_CONFLICT;
            end else begin
              tgt_d     = prio_rd[BW-1:0] + BW'(1);
              do_link_d = 1'b1;
              state_d   = bpq_pkg::S_UNLINK;
            end
          end
          bpq_pkg::OP_DECREMENT: begin
            if (prio_rd[PW-1]) begin
              status_d = bpq_pkg::ST_ABSENT;
            end else if (prio_rd != '0) begin
              tgt_d     = prio_rd[BW-1:0] - BW'(1);
              do_link_d = 1'b1;
              state_d   = bpq_pkg::S_UNLINK;
            end
          end
          default: begin
            state_d = bpq_pkg::S_FINISH;
          end
        endcase
      end
      bpq_pkg::S_UNLINK: begin
        if (hb_head == p_idx && hb_tail == p_idx) begin
          nonempty_d[hb_idx] = 1'b0;
        end else if (hb_head == p_idx) begin
          head_we = 1'b1; head_wdata = nxt_q;
        end else if (hb_tail == p_idx) begin
          tail_we = 1'b1; tail_wdata = prv_q;
          next_we = 1'b1; next_wa = prv_q; next_wd = nxt_q;
        end else begin
          next_we = 1'b1; next_wa = prv_q; next_wd = nxt_q;
          prev_we = 1'b1; prev_wa = nxt_q; prev_wd = prv_q;
        end
        if (held_q != '0) begin
          held_d = held_q - CNT_W'(1);
        end
        if (cur_q == '0 && usable_q && ubot_q != '0) begin
          ubot_d = ubot_q - CNT_W'(1);
        end
        prio_we    = 1'b1;
        prio_wd    = '1;
        fin_prio_d = '1;
        state_d    = do_link_q ? bpq_pkg::S_LINK_A : bpq_pkg::S_FINISH;
      end
      bpq_pkg::S_LINK_A: begin
        if (nonempty_q[hb_idx]) begin
          next_we = 1'b1; next_wa = hb_tail; next_wd = p_idx;
          prev_we = 1'b1; prev_wd = hb_tail;
        end else begin
          head_we = 1'b1; head_wdata = p_idx;
          prev_we = 1'b1; prev_wd = p_idx;
          nonempty_d[hb_idx] = 1'b1;
        end
        state_d = bpq_pkg::S_LINK_B;
      end
      bpq_pkg::S_LINK_B: begin
        next_we = 1'b1; next_wd = p_idx;
        tail_we = 1'b1; tail_wdata = p_idx;
        prio_we = 1'b1; prio_wd = {1'b0, tgt_q};
        use_we  = 1'b1; use_wd = new_usable_q;
        held_d  = held_q + CNT_W'(1);
        if (tgt_q == '0 && new_usable_q) begin
          ubot_d = ubot_q + CNT_W'(1);
        end
        fin_prio_d = {1'b0, tgt_q};
        state_d    = bpq_pkg::S_FINISH;
      end
      bpq_pkg::S_FINISH: begin
        if (out_load) begin
          state_d = bpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bpq_pkg::S_IDLE;
      end
    endcase
  end

  assign head_wide = 32'(hb_head);
  assign held_wide = 32'(held_q);
  assign prio_wide = 32'(int'($signed(fin_prio_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpq_pkg::S_SWEEP;
      num_q       <= bpq_pkg::NUM_POINTS_RST;
      restart_q   <= 1'b0;
      cnt_q       <= '0;
      nonempty_q  <= '0;
      held_q      <= '0;
      ubot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      restart_q  <= restart_d;
      cnt_q      <= cnt_d;
      nonempty_q <= nonempty_d;
      held_q     <= held_d;
      ubot_q     <= ubot_d;
      if (cfg_we_i) begin
        num_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    p_q          <= p_d;
    req_q        <= req_d;
    in_range_q   <= in_range_d;
    cur_q        <= cur_d;
    usable_q     <= usable_d;
    new_usable_q <= new_usable_d;
    nxt_q        <= nxt_d;
    prv_q        <= prv_d;
    tgt_q        <= tgt_d;
    do_link_q    <= do_link_d;
    fin_prio_q   <= fin_prio_d;
    status_q     <= status_d;
    if (head_we) begin
      heads_q[head_widx] <= head_wdata;
    end
    if (tail_we) begin
      tails_q[tail_widx] <= tail_wdata;
    end
    if (out_load) begin
      out_status_q <= status_q;
      out_next_q   <= any ? head_wide[11:0] : '0;
      out_nvalid_q <= any;
      out_done_q   <= (nonempty_q[NUM_BUCKETS-1:1] == '0) && (ubot_q == '0);
      out_total_q  <= held_wide[12:0];
      out_prio_q   <= prio_wide[4:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign next_point_o     = out_next_q;
  assign next_valid_o     = out_nvalid_q;
  assign queue_done_o     = out_done_q;
  assign total_count_o    = out_total_q;
  assign point_priority_o = $signed(out_prio_q);

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench of the bucket priority queue: directed table, random phases, predictor
`timescale 1ns / 100ps

module tb_top;

  localparam int NPTS = bpq_pkg::MAX_POINTS_DEF;
  localparam int NBKT = bpq_pkg::NUM_BUCKETS_DEF;
  localparam logic [2:0] OP_SPARE = 3'd7;

  typedef struct packed {
    logic [1:0]        status;
    logic [11:0]       next_point;
    logic              next_valid;
    logic              queue_done;
    logic [12:0]       total_count;
    logic signed [4:0] point_priority;
  } qres_t;

  typedef struct {
    logic [2:0]        op;
    logic [11:0]       point;
    logic signed [4:0] prio;
    bit                typed;
    qres_t             res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [12:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] op_i = '0;
  logic [11:0] point_i = '0;
  logic signed [4:0] priority_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [11:0] next_point_o;
  logic next_valid_o;
  logic queue_done_o;
  logic [12:0] total_count_o;
  logic signed [4:0] point_priority_o;

  bit    cur_typed = 1'b0;
  qres_t cur_res = '0;

  qres_t result_q[$];
  row_t  dir_tab[$];
  int    fails = 0;
  int    n_sent = 0;
  int    n_checked = 0;
  int    n_phases = 0;
  bit    quiet = 1'b0;
  bit    hold_req = 1'b0;

  // predictor state
  int        prio_of[NPTS];
  bit        usable[NPTS];
  int        link_nx[NPTS];
  int        link_pv[NPTS];
  int        head_of[NBKT];
  int        tail_of[NBKT];
  bit [NBKT-1:0] filled;
  int        held;
  int        usable_low;
  int        points_cfg;

  bucket_priority_queue dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int points_eff();
    if (points_cfg < 1) return 1;
    if (points_cfg > NPTS) return NPTS;
    return points_cfg;
  endfunction

  function automatic void bq_unlink(int p);
    int b;
    int pv;
    int nx;
    b = prio_of[p];
    if (b < 0) return;
    pv = link_pv[p];
    nx = link_nx[p];
    if (head_of[b] == p && tail_of[b] == p) filled[b] = 1'b0;
    else if (head_of[b] == p) head_of[b] = nx;
    else if (tail_of[b] == p) begin
      tail_of[b] = pv;
      link_nx[pv] = nx;
    end else begin
      link_nx[pv] = nx;
      link_pv[nx] = pv;
    end
    if (held > 0) held--;
    if (b == 0 && usable[p] && usable_low > 0) usable_low--;
    prio_of[p] = -1;
  endfunction

  function automatic void bq_link(int p, int b);
    if (filled[b]) begin
      link_nx[tail_of[b]] = p;
      link_pv[p] = tail_of[b];
    end else begin
      head_of[b] = p;
      link_pv[p] = p;
      filled[b] = 1'b1;
    end
    link_nx[p] = p;
    tail_of[b] = p;
    prio_of[p] = b;
    held++;
    if (b == 0 && usable[p]) usable_low++;
  endfunction

  function automatic void bq_clear();
    for (int i = 0; i < NPTS; i++) begin
      prio_of[i] = -1;
      usable[i] = 1'b1;
    end
    filled = '0;
    held = 0;
    usable_low = 0;
  endfunction

  function automatic qres_t bq_apply(logic [2:0] op, int p, int req);
    qres_t r;
    bit in_rng;
    int cur;
    int top;
    r = '0;
    r.status = bpq_pkg::ST_OK;
    in_rng = p < points_eff();
    cur = in_rng ? prio_of[p] : -1;
    if (op == bpq_pkg::OP_RESTART) begin
      bq_clear();
      for (int i = 0; i < points_eff(); i++) bq_link(i, 0);
    end else if (op == bpq_pkg::OP_QUERY || op == OP_SPARE) begin
      if (!in_rng) r.status = bpq_pkg::ST_RANGE;
    end else if (!in_rng) r.status = bpq_pkg::ST_RANGE;
    else if (op == bpq_pkg::OP_ADD) begin
      if (cur >= 0 || req < 0 || req >= NBKT) r.status = bpq_pkg::ST_CONFLICT;
      else bq_link(p, req);
    end else if (cur < 0) r.status = bpq_pkg::ST_ABSENT;
    else if (op == bpq_pkg::OP_REMOVE) bq_unlink(p);
    else if (op == bpq_pkg::OP_MOVE) begin
      if (req >= NBKT) r.status = bpq_pkg::ST_CONFLICT;
      else begin
        bq_unlink(p);
        usable[p] = req >= 0;
        bq_link(p, req < 0 ? 0 : req);
      end
    end else if (op == bpq_pkg::OP_INCREMENT) begin
      if (cur + 1 >= NBKT) r.status = bpq_pkg::ST_CONFLICT;
      else begin
        bq_unlink(p);
        bq_link(p, cur + 1);
      end
    end else if (cur > 0) begin
      bq_unlink(p);
      bq_link(p, cur - 1);
    end
    top = -1;
    for (int b = 0; b < NBKT; b++) if (filled[b]) top = b;
    r.next_valid = top >= 0;
    r.next_point = top >= 0 ? head_of[top][11:0] : 12'd0;
    r.queue_done = (filled[NBKT-1:1] == '0) && usable_low == 0;
    r.total_count = held[12:0];
    r.point_priority = (p < points_eff()) ? prio_of[p][4:0] : -5'sd1;
    return r;
  endfunction

  // input transactions feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      qres_t r;
      r = bq_apply(op_i, point_i, priority_req_i);
      result_q.insert(result_q.size(), cur_typed ? cur_res : r);
      n_sent++;
    end
  end

  // output transactions checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      qres_t e;
      if (result_q.size() == 0) begin
        $error("result with no expectation waiting");
        fails++;
      end else begin
        e = result_q.pop_front();
        n_checked++;
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          fails++;
        end
        if (next_point_o !== e.next_point) begin
          $error("next_point: expected %0d, got %0d", e.next_point, next_point_o);
          fails++;
        end
        if (next_valid_o !== e.next_valid) begin
          $error("next_valid: expected %0d, got %0d", e.next_valid, next_valid_o);
          fails++;
        end
        if (queue_done_o !== e.queue_done) begin
          $error("queue_done: expected %0d, got %0d", e.queue_done, queue_done_o);
          fails++;
        end
        if (total_count_o !== e.total_count) begin
          $error("total_count: expected %0d, got %0d", e.total_count, total_count_o);
          fails++;
        end
        if (point_priority_o !== e.point_priority) begin
          $error("point_priority: expected %0d, got %0d", e.point_priority,
                 point_priority_o);
          fails++;
        end
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int burst;
    forever begin
      @(posedge clk_i);
      if (quiet) out_stall_i <= 1'b0;
      else if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 17);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send(logic [2:0] op, logic [11:0] p, logic signed [4:0] pr, bit typed,
                      qres_t res);
    in_valid_i <= 1'b1;
    op_i <= op;
    point_i <= p;
    priority_req_i <= pr;
    cur_typed <= typed;
    cur_res <= res;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic drain(int extra);
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic set_points(logic [12:0] v);
    drain(12);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    points_cfg = v;
    n_phases++;
  endtask

  function automatic void row(logic [2:0] op, int p, int pr, bit typed, qres_t res);
    row_t t;
    t.op = op;
    t.point = 12'(p);
    t.prio = 5'(pr);
    t.typed = typed;
    t.res = res;
    dir_tab.insert(dir_tab.size(), t);
  endfunction

  initial begin
    #(8 * 3_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [12:0] settings[8];
    qres_t none;
    int cnt;
    int sel;
    logic [2:0] op;
    logic [11:0] p;
    logic signed [4:0] pr;
    settings = '{13'd8, 13'd1, 13'd40, 13'd4096, 13'h1fff, 13'd0, 13'd200, 13'd16};
    none = '0;
    bq_clear();
    points_cfg = bpq_pkg::NUM_POINTS_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    row(bpq_pkg::OP_QUERY, 0, 0, 1,
        '{bpq_pkg::ST_OK, 12'd0, 1'b0, 1'b1, 13'd0, -5'sd1});
    row(bpq_pkg::OP_REMOVE, 5, 0, 1,
        '{bpq_pkg::ST_ABSENT, 12'd0, 1'b0, 1'b1, 13'd0, -5'sd1});
    row(bpq_pkg::OP_ADD, 0, -1, 1,
        '{bpq_pkg::ST_CONFLICT, 12'd0, 1'b0, 1'b1, 13'd0, -5'sd1});
    row(bpq_pkg::OP_ADD, 3, 15, 1,
        '{bpq_pkg::ST_OK, 12'd3, 1'b1, 1'b0, 13'd1, 5'sd15});
    row(bpq_pkg::OP_ADD, 3, 2, 1,
        '{bpq_pkg::ST_CONFLICT, 12'd3, 1'b1, 1'b0, 13'd1, 5'sd15});
    row(bpq_pkg::OP_INCREMENT, 3, 0, 1,
        '{bpq_pkg::ST_CONFLICT, 12'd3, 1'b1, 1'b0, 13'd1, 5'sd15});
    row(bpq_pkg::OP_ADD, 7, 0, 0, none);
    row(bpq_pkg::OP_DECREMENT, 7, 0, 0, none);
    row(bpq_pkg::OP_MOVE, 7, -1, 0, none);
    row(bpq_pkg::OP_ADD, 4, 15, 0, none);
    row(bpq_pkg::OP_MOVE, 3, 15, 0, none);
    row(OP_SPARE, 3, 0, 0, none);
    row(bpq_pkg::OP_DECREMENT, 4, 0, 0, none);
    row(bpq_pkg::OP_INCREMENT, 7, 0, 0, none);
    row(bpq_pkg::OP_ADD, 4095, 0, 0, none);
    row(bpq_pkg::OP_ADD, 9, -16, 0, none);
    row(bpq_pkg::OP_MOVE, 4095, -16, 0, none);
    row(bpq_pkg::OP_REMOVE, 3, 0, 0, none);
    row(bpq_pkg::OP_REMOVE, 3, 0, 0, none);
    row(bpq_pkg::OP_DECREMENT, 3, 0, 0, none);
    row(bpq_pkg::OP_RESTART, 2730, 0, 0, none);
    row(bpq_pkg::OP_MOVE, 0, 15, 0, none);
    row(bpq_pkg::OP_QUERY, 4095, 0, 0, none);
    foreach (dir_tab[i])
      send(dir_tab[i].op, dir_tab[i].point, dir_tab[i].prio, dir_tab[i].typed,
           dir_tab[i].res);

    foreach (settings[ph]) begin
      set_points(settings[ph]);
      if (ph == 2) hold_req = 1'b1;
      if (ph == 7) quiet = 1'b1;
      cnt = (settings[ph] == 13'd1 || settings[ph] == 13'd0) ? 130 : 240;
      send(bpq_pkg::OP_RESTART, 12'($urandom), 5'($urandom), 0, none);
      for (int i = 0; i < cnt; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 26) op = bpq_pkg::OP_ADD;
        else if (sel < 36) op = bpq_pkg::OP_REMOVE;
        else if (sel < 52) op = bpq_pkg::OP_MOVE;
        else if (sel < 70) op = bpq_pkg::OP_INCREMENT;
        else if (sel < 86) op = bpq_pkg::OP_DECREMENT;
        else if (sel < 95) op = bpq_pkg::OP_QUERY;
        else if (sel < 98) op = OP_SPARE;
        else if (sel < 99 && $urandom_range(0, 1) == 0) op = bpq_pkg::OP_RESTART;
        else op = 3'($urandom);
        if ($urandom_range(0, 99) < 85) p = 12'($urandom_range(0, points_eff() - 1));
        else p = 12'($urandom);
        sel = $urandom_range(0, 9);
        if (sel < 8) pr = 5'($urandom_range(0, 15));
        else if (sel < 9) pr = -5'sd1;
        else pr = 5'($urandom);
        send(op, p, pr, 0, none);
      end
    end
    drain(30);
    $display("%0d transactions sent, %0d results checked", n_sent, n_checked);
    $display("%0d point-count settings, one long output hold-off", n_phases);
    if (fails == 0 && result_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
